@@ src/fpcrm_pkg.sv @@
// Shared constants, types and rotation tables for the cube-rotation frame matcher.
package fpcrm_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int AXES           = 3;
    localparam int AXIS_W         = AXES * COMPONENT_BITS;
    localparam int ROTATION_COUNT = 24;
    localparam int INDEX_W        = 5;

    localparam int PROD_W = 2 * COMPONENT_BITS;
    localparam int DOT_W  = PROD_W + 2;
    localparam int CORR_W = DOT_W + 2;

    localparam int S_TDATA_W = 2 * AXES * AXIS_W;
    localparam int M_TDATA_W = 8;

    localparam int GROUP4_COUNT = ROTATION_COUNT / 4;
    localparam int GROUP3_COUNT = GROUP4_COUNT / 3;

    typedef logic [1:0] axis_sel_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] score;
        logic [INDEX_W-1:0]       idx;
    } cand_t;

    // Column of the nonzero entry in each row of rotation n, in generation order.
    localparam axis_sel_t ROT_COL [ROTATION_COUNT][AXES] = '{
        '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd1},
        '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd1, 2'd2}, '{2'd0, 2'd2, 2'd1}, '{2'd0, 2'd2, 2'd1},
        '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd1, 2'd2, 2'd0},
        '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd0, 2'd2}, '{2'd1, 2'd2, 2'd0}, '{2'd1, 2'd2, 2'd0},
        '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0},
        '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd1, 2'd0}
    };

    // Sign of that entry: set means negative.
    localparam logic [AXES-1:0] ROT_NEG [ROTATION_COUNT] = '{
        3'b101, 3'b011, 3'b001, 3'b111, 3'b000, 3'b110, 3'b100, 3'b010,
        3'b001, 3'b111, 3'b101, 3'b011, 3'b100, 3'b010, 3'b000, 3'b110,
        3'b101, 3'b011, 3'b001, 3'b111, 3'b000, 3'b110, 3'b100, 3'b010
    };

endpackage

@@ src/frame_pair_cube_rotation_match.sv @@
// Top level of the cube-rotation frame matcher: six-stage pipelined datapath.
//
// Takes a pair of frames, three axis vectors each (three signed Q2.14 components
// per axis, component 0 in the low bits), and returns the index 0..23 of the cube
// rotation R_n that brings the second frame closest to the first in squared
// Frobenius distance, in the table generation order; on a tie the lowest index
// wins. The search maximizes the exact correlation sum_r s_r * dot(first_r,
// second_c_r), which is equivalent. One pair is taken every cycle unless the
// output stalls; stage 1 forms the 27 component products, stage 2 the nine
// axis dot products, stage 3 the 24 signed correlations, and stages 4 to 6
// hold a registered maximum search (groups of four, then three, then a final
// pair), the last stage being the output register. The whole pipeline holds
// while a result waits to be taken, so s_tready follows m_tready combinationally
// when the output register is full. Any bit pattern is accepted.
module frame_pair_cube_rotation_match (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0 up: first_x_axis, first_y_axis, first_z_axis,
    // second_x_axis, second_y_axis, second_z_axis (48 bits each)
    input  logic [fpcrm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fields from bit 0 up: best_rotation (5 bits), zero fill to 8 bits
    output logic [fpcrm_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpcrm_pkg::*;

    logic advance;

    // Valid bits, one per stage.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic signed [PROD_W-1:0] prod_next [AXES][AXES][AXES];
    logic signed [PROD_W-1:0] prod_reg  [AXES][AXES][AXES];
    logic signed [DOT_W-1:0]  dot_next  [AXES][AXES];
    logic signed [DOT_W-1:0]  dot_reg   [AXES][AXES];
    logic signed [CORR_W-1:0] corr_next [ROTATION_COUNT];
    logic signed [CORR_W-1:0] corr_reg  [ROTATION_COUNT];
    cand_t                    g4_next   [GROUP4_COUNT];
    cand_t                    g4_reg    [GROUP4_COUNT];
    cand_t                    g3_next   [GROUP3_COUNT];
    cand_t                    g3_reg    [GROUP3_COUNT];
    logic [INDEX_W-1:0]       best_next;
    logic [INDEX_W-1:0]       best_reg;

    // Move every stage together whenever the output register is free or drained.
    assign advance  = !v6_reg || m_tready;
    assign s_tready = advance;

    assign m_tvalid = v6_reg;
    assign m_tdata  = {{(M_TDATA_W-INDEX_W){1'b0}}, best_reg};

    // Stage 1: product of component i of first axis r with component i of second axis c.
    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            for (int c = 0; c < AXES; c++) begin
                for (int i = 0; i < AXES; i++) begin
                    prod_next[r][c][i] =
                        $signed(s_tdata[r*AXIS_W + i*COMPONENT_BITS +: COMPONENT_BITS]) *
                        $signed(s_tdata[(AXES+c)*AXIS_W + i*COMPONENT_BITS +: COMPONENT_BITS]);
                end
            end
        end
    end

    // Stage 2: dot products of every first axis with every second axis.
    always_comb begin
        for (int r = 0; r < AXES; r++) begin
            for (int c = 0; c < AXES; c++) begin
                dot_next[r][c] = DOT_W'(prod_reg[r][c][0]) + DOT_W'(prod_reg[r][c][1])
                               + DOT_W'(prod_reg[r][c][2]);
            end
        end
    end

    // Stage 3: correlation of each rotation, one signed dot product per row.
    always_comb begin
        logic signed [CORR_W-1:0] term;
        for (int n = 0; n < ROTATION_COUNT; n++) begin
            corr_next[n] = '0;
            for (int r = 0; r < AXES; r++) begin
                term = CORR_W'(dot_reg[r][ROT_COL[n][r]]);
                corr_next[n] = ROT_NEG[n][r] ? corr_next[n] - term : corr_next[n] + term;
            end
        end
    end

    // Stage 4: best of each group of four; a later index replaces only when strictly larger.
    always_comb begin
        for (int g = 0; g < GROUP4_COUNT; g++) begin
            g4_next[g].score = corr_reg[4*g];
            g4_next[g].idx   = INDEX_W'(4*g);
            for (int k = 1; k < 4; k++) begin
                if (corr_reg[4*g+k] > g4_next[g].score) begin
                    g4_next[g].score = corr_reg[4*g+k];
                    g4_next[g].idx   = INDEX_W'(4*g+k);
                end
            end
        end
    end

    // Stage 5: best of each group of three group winners.
    always_comb begin
        for (int g = 0; g < GROUP3_COUNT; g++) begin
            g3_next[g] = g4_reg[3*g];
            for (int k = 1; k < 3; k++) begin
                if (g4_reg[3*g+k].score > g3_next[g].score) begin
                    g3_next[g] = g4_reg[3*g+k];
                end
            end
        end
    end

    // Stage 6: final pair; the lower half keeps ties.
    always_comb begin
        if (g3_reg[1].score > g3_reg[0].score) begin
            best_next = g3_reg[1].idx;
        end else begin
            best_next = g3_reg[0].idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Payload registers hold with the valid bits and need no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
            corr_reg <= corr_next;
            g4_reg   <= g4_next;
            g3_reg   <= g3_next;
            best_reg <= best_next;
        end
    end

endmodule

@@ src/fpcrm_checker.sv @@
// Port-level checks for the cube-rotation frame matcher, bound to the top level.
module fpcrm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fpcrm_pkg::M_TDATA_W-1:0] m_tdata
);
    import fpcrm_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The reported index names one of the 24 rotations and the fill bits stay clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:INDEX_W] == '0)
                     && (m_tdata[INDEX_W-1:0] < INDEX_W'(ROTATION_COUNT)))
        else $error("rotation index out of range");

    // The input side is never held off while the output register can drain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with output free");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result present right after reset");

endmodule

bind frame_pair_cube_rotation_match fpcrm_checker u_fpcrm_checker (.*);
